[hw/rtl/pktdf_pkg.sv]
package pktdf_pkg;

    // Framing bytes.
    localparam logic [7:0] SYNC_BYTE  = 8'h5A;
    localparam logic [7:0] TYPE_DATA  = 8'hA5;
    localparam logic [7:0] TYPE_PING  = 8'hA6;
    localparam logic [7:0] TYPE_REPLY = 8'hA7;

    // A ping reply always carries this many payload bytes.
    localparam logic [15:0] REPLY_BYTES = 16'd8;

    // CRC-16/XMODEM generator polynomial and top bit.
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    // Parser phase codes.
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_LEN_HI  = 3'd3;
    localparam logic [2:0] PH_CRC_LO  = 3'd4;
    localparam logic [2:0] PH_CRC_HI  = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;

    // Frame event codes.
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_PING     = 3'd1;
    localparam logic [2:0] EV_CRC_OK   = 3'd2;
    localparam logic [2:0] EV_CRC_ERR  = 3'd3;
    localparam logic [2:0] EV_REPLY    = 3'd4;
    localparam logic [2:0] EV_OVERFLOW = 3'd5;

    // One result item.
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic [2:0]  frame_event;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
        logic [15:0] crc_sent;
        logic [15:0] crc_found;
    } t_result;

    // Byte-wide CRC-16/XMODEM update, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_MSB) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // CRC after the sync and data type bytes, seeded with zero.
    localparam logic [15:0] CRC_HDR_SEED = crc16_byte(crc16_byte(16'h0000, SYNC_BYTE), TYPE_DATA);

endpackage

[hw/rtl/pktdf_in_reg.sv]
module pktdf_in_reg
    import pktdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_take
);

    logic       r_valid;
    logic [7:0] r_byte;

    // The register frees up in the same cycle its request is taken.
    assign o_ready = !r_valid || i_take;

    // Valid flag of the held request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Received byte, loaded on acceptance.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    // A held byte that is not taken must stay put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_take |=> r_valid && $stable(r_byte))
        else $error("input register lost a held request");

    // A take is only issued for a held request.
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take |-> r_valid)
        else $error("take without a held request");

    // After reset the register is empty.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("input register not empty after reset");

endmodule

[hw/rtl/pktdf_parser.sv]
module pktdf_parser
    import pktdf_pkg::*;
#(
    parameter int BUFFER_BYTES = 256
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_take,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_result    o_res
);

    localparam int OFF_W = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W = (OFF_W > 16) ? OFF_W : 16;

    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_kind, n_kind;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_hcrc, n_hcrc;
    logic [15:0]      r_rcrc, n_rcrc;
    logic [OFF_W-1:0] r_off, n_off;
    logic [OFF_W-1:0] off_inc;
    logic [15:0]      crc_upd;
    logic             r_res_valid;
    t_result          r_res, n_res;

    // A request advances when the result register is free or drains now.
    assign o_take = i_valid && (!r_res_valid || i_res_ready);

    assign off_inc = r_off + 1'b1;
    assign crc_upd = crc16_byte(r_rcrc, i_byte);

    // Frame parsing and result formation for one received byte.
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_len   = r_len;
        n_hcrc  = r_hcrc;
        n_rcrc  = r_rcrc;
        n_off   = r_off;
        n_res   = '0;
        case (r_phase)
            PH_IDLE: begin
                if (i_byte == SYNC_BYTE) begin
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                // An unknown type is recorded and the type byte is awaited again.
                n_kind = i_byte;
                if (i_byte == TYPE_DATA) begin
                    n_rcrc  = CRC_HDR_SEED;
                    n_phase = PH_LEN_LO;
                end else if (i_byte == TYPE_PING) begin
                    n_len             = 16'h0000;
                    n_res.frame_event = EV_PING;
                    n_phase           = PH_IDLE;
                end else if (i_byte == TYPE_REPLY) begin
                    n_len   = REPLY_BYTES;
                    n_off   = '0;
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_LEN_LO: begin
                n_len   = {8'h00, i_byte};
                n_rcrc  = crc_upd;
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len   = {i_byte, r_len[7:0]};
                n_rcrc  = crc_upd;
                n_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                n_hcrc  = {8'h00, i_byte};
                n_phase = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                n_hcrc  = {i_byte, r_hcrc[7:0]};
                n_off   = '0;
                n_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_res.payload_valid = 1'b1;
                n_res.payload_byte  = i_byte;
                n_res.payload_index = 8'(r_off);
                n_off               = off_inc;
                if (r_kind == TYPE_DATA) begin
                    n_rcrc = crc_upd;
                end
                if (r_kind == TYPE_REPLY && CMP_W'(off_inc) >= CMP_W'(REPLY_BYTES)) begin
                    n_len             = REPLY_BYTES;
                    n_res.frame_event = EV_REPLY;
                    n_phase           = PH_IDLE;
                end
                // Overflow wins over a data frame completing on the same byte.
                if (off_inc >= OFF_W'(BUFFER_BYTES)) begin
                    n_res.frame_event = EV_OVERFLOW;
                    n_phase           = PH_IDLE;
                    n_off             = '0;
                end else if (r_kind == TYPE_DATA && CMP_W'(off_inc) >= CMP_W'(r_len)) begin
                    n_res.crc_sent    = r_hcrc;
                    n_res.crc_found   = n_rcrc;
                    n_res.frame_event = (n_rcrc == r_hcrc) ? EV_CRC_OK : EV_CRC_ERR;
                    n_phase           = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        n_res.frame_type   = n_kind;
        n_res.frame_length = n_len;
    end

    // Frame state, updated once per advanced request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= 8'h00;
            r_len   <= 16'h0000;
            r_hcrc  <= 16'h0000;
            r_rcrc  <= 16'h0000;
            r_off   <= '0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_len   <= n_len;
            r_hcrc  <= n_hcrc;
            r_rcrc  <= n_rcrc;
            r_off   <= n_off;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (!r_res_valid || i_res_ready) begin
            r_res_valid <= i_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // A CRC verdict only comes with a payload byte.
    a_crc_with_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && (r_res.frame_event == EV_CRC_OK || r_res.frame_event == EV_CRC_ERR)
        |-> r_res.payload_valid && r_res.frame_type == TYPE_DATA)
        else $error("CRC verdict without a data payload byte");

    // CRC fields are zero outside a CRC verdict.
    a_crc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.frame_event != EV_CRC_OK && r_res.frame_event != EV_CRC_ERR
        |-> r_res.crc_sent == 16'h0000 && r_res.crc_found == 16'h0000)
        else $error("CRC fields set without a verdict");

    // The ok verdict agrees with the compared values.
    a_crc_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.frame_event == EV_CRC_OK |-> r_res.crc_sent == r_res.crc_found)
        else $error("CRC ok reported on mismatch");

    // Overflow lands on the last buffer slot.
    a_overflow_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.frame_event == EV_OVERFLOW
        |-> r_res.payload_valid && r_res.payload_index == 8'(BUFFER_BYTES - 1))
        else $error("overflow at the wrong offset");

    // A ping reports the ping type and zero length.
    a_ping: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.frame_event == EV_PING
        |-> r_res.frame_type == TYPE_PING && r_res.frame_length == 16'h0000
            && !r_res.payload_valid)
        else $error("malformed ping event");

endmodule

[hw/rtl/imu_packet_deframer_crc16.sv]
// An accepted byte waits in the input register until the parser takes it; its result
// is then held in the result register until it is taken on the result side.
// Throughput: one byte per cycle while the result side is ready; the byte-wide CRC-16
// update and phase logic are combinational between the input and result registers.
// Stalls on the result side back up through both registers as each one fills.
// Reset (i_rst_n low, synchronous) empties both registers and returns the parser
// to idle with type, length and CRC state cleared; there is no clearing pass.
module imu_packet_deframer_crc16
    import pktdf_pkg::*;
#(
    parameter int BUFFER_BYTES = 256
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_payload_index,
    output logic [2:0]  o_frame_event,
    output logic [7:0]  o_frame_type,
    output logic [15:0] o_frame_length,
    output logic [15:0] o_crc_sent,
    output logic [15:0] o_crc_found
);

    logic       held_valid;
    logic [7:0] held_byte;
    logic       take;
    t_result    res;

    // Input register that parts the byte source from the parser.
    pktdf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx_valid),
        .o_ready (o_rx_ready),
        .i_byte  (i_rx_byte),
        .o_valid (held_valid),
        .o_byte  (held_byte),
        .i_take  (take)
    );

    // Frame parser with its result register.
    pktdf_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (held_valid),
        .i_byte      (held_byte),
        .o_take      (take),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (res)
    );

    // Result fields out to their ports.
    assign o_payload_valid = res.payload_valid;
    assign o_payload_byte  = res.payload_byte;
    assign o_payload_index = res.payload_index;
    assign o_frame_event   = res.frame_event;
    assign o_frame_type    = res.frame_type;
    assign o_frame_length  = res.frame_length;
    assign o_crc_sent      = res.crc_sent;
    assign o_crc_found     = res.crc_found;

endmodule
